// ===== hdl/irc_tok_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_tok_pkg
// shared codes, result type and character constants of the irc line tokenizer
// ----------------------------------------------------------------------------
package irc_tok_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_END   = 8'h00;

    typedef enum logic [1:0] {
        EV_BYTE  = 2'd0,
        EV_TOKEN = 2'd1,
        EV_LINE  = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        TK_PREFIX = 2'd0,
        TK_CMD    = 2'd1,
        TK_MIDDLE = 2'd2,
        TK_TRAIL  = 2'd3
    } t_token;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NO_CMD   = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        t_event      event_kind;
        t_token      token_kind;
        logic [3:0]  param_index;
        logic [7:0]  data_byte;
        logic [4:0]  param_count;
        t_status     line_status;
        logic        last_of_run;
    } t_result;

    // up to two results come out of one byte
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_res_pair;

endpackage

// ===== hdl/irc_tok_if.sv =====
// ----------------------------------------------------------------------------
// irc_tok_if
// valid/ready channels for line bytes in and token results out
// ----------------------------------------------------------------------------
interface irc_tok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

interface irc_tok_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [1:0] token_kind;
    logic [3:0] param_index;
    logic [7:0] data_byte;
    logic [4:0] param_count;
    logic [1:0] line_status;
    logic       last_of_run;

    modport source (output valid, output event_kind, output token_kind,
                    output param_index, output data_byte, output param_count,
                    output line_status, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input token_kind,
                    input param_index, input data_byte, input param_count,
                    input line_status, input last_of_run, output ready);
endinterface

// ===== hdl/irc_tok_core.sv =====
// ----------------------------------------------------------------------------
// irc_tok_core
// line parse state and per-byte decode into up to two token results
// ----------------------------------------------------------------------------
module irc_tok_core #(
    parameter int MAX_PARAMS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_byte,
    output irc_tok_pkg::t_res_pair o_pair
);
    import irc_tok_pkg::*;

    localparam int CW = $clog2(MAX_PARAMS + 1);

    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_PRECMD,
        PH_CMD,
        PH_AFTERCMD,
        PH_PARAM,
        PH_TRAIL,
        PH_DROP
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_tok_start, n_tok_start;
    logic [3:0]      idx4;
    logic [4:0]      cnt5;
    logic [4:0]      cnt5_inc;
    logic [CW-1:0]   cnt_inc;
    t_result         res0, res1;
    logic            v0, v1;

    function automatic t_result mk(t_event ev, t_token tk, logic [3:0] idx,
                                   logic [7:0] db, logic [4:0] cnt, t_status st);
        t_result r;
        r.event_kind  = ev;
        r.token_kind  = tk;
        r.param_index = idx;
        r.data_byte   = db;
        r.param_count = cnt;
        r.line_status = st;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    assign idx4     = 4'(r_cnt);
    assign cnt5     = 5'(r_cnt);
    assign cnt5_inc = cnt5 + 5'd1;
    assign cnt_inc  = r_cnt + CW'(1);

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_tok_start = r_tok_start;
        v0          = 1'b0;
        v1          = 1'b0;
        res0        = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, 5'd0, ST_OK);
        res1        = res0;
        unique case (r_phase)
            PH_START: begin
                if (i_byte == CH_END) begin
                    v0   = 1'b1;
                    res0 = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, 5'd0, ST_EMPTY);
                end else if (i_byte == CH_COLON) begin
                    n_phase = PH_PREFIX;
                end else if (i_byte == CH_SPACE) begin
                    n_phase = PH_PRECMD;
                end else begin
                    v0      = 1'b1;
                    res0    = mk(EV_BYTE, TK_CMD, 4'd0, i_byte, 5'd0, ST_OK);
                    n_phase = PH_CMD;
                end
            end
            PH_PREFIX: begin
                if (i_byte == CH_END) begin
                    v0   = 1'b1;
                    v1   = 1'b1;
                    res0 = mk(EV_TOKEN, TK_PREFIX, 4'd0, 8'd0, 5'd0, ST_OK);
                    res1 = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, 5'd0, ST_EMPTY);
                end else if (i_byte == CH_SPACE) begin
                    v0      = 1'b1;
                    res0    = mk(EV_TOKEN, TK_PREFIX, 4'd0, 8'd0, 5'd0, ST_OK);
                    n_phase = PH_PRECMD;
                end else begin
                    v0   = 1'b1;
                    res0 = mk(EV_BYTE, TK_PREFIX, 4'd0, i_byte, 5'd0, ST_OK);
                end
            end
            PH_PRECMD: begin
                if (i_byte == CH_END) begin
                    v0   = 1'b1;
                    res0 = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, 5'd0, ST_NO_CMD);
                end else if (i_byte != CH_SPACE) begin
                    v0      = 1'b1;
                    res0    = mk(EV_BYTE, TK_CMD, 4'd0, i_byte, 5'd0, ST_OK);
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (i_byte == CH_END) begin
                    v0   = 1'b1;
                    v1   = 1'b1;
                    res0 = mk(EV_TOKEN, TK_CMD, 4'd0, 8'd0, 5'd0, ST_OK);
                    res1 = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, 5'd0, ST_OK);
                end else if (i_byte == CH_SPACE) begin
                    v0      = 1'b1;
                    res0    = mk(EV_TOKEN, TK_CMD, 4'd0, 8'd0, 5'd0, ST_OK);
                    n_phase = PH_AFTERCMD;
                end else begin
                    v0   = 1'b1;
                    res0 = mk(EV_BYTE, TK_CMD, 4'd0, i_byte, 5'd0, ST_OK);
                end
            end
            PH_AFTERCMD: begin
                if (i_byte == CH_END) begin
                    v0   = 1'b1;
                    res0 = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, 5'd0, ST_OK);
                end else if (i_byte == CH_COLON) begin
                    n_phase = PH_TRAIL;
                end else if (i_byte != CH_SPACE) begin
                    v0          = 1'b1;
                    res0        = mk(EV_BYTE, TK_MIDDLE, idx4, i_byte, 5'd0, ST_OK);
                    n_phase     = PH_PARAM;
                    n_tok_start = 1'b0;
                end
            end
            PH_PARAM: begin
                // a line end right after a space still closes an empty param
                if (i_byte == CH_END) begin
                    v0   = 1'b1;
                    v1   = 1'b1;
                    res0 = mk(EV_TOKEN, TK_MIDDLE, idx4, 8'd0, 5'd0, ST_OK);
                    res1 = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, cnt5_inc, ST_OK);
                end else if (r_tok_start) begin
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_TRAIL;
                    end else if (i_byte != CH_SPACE) begin
                        v0          = 1'b1;
                        res0        = mk(EV_BYTE, TK_MIDDLE, idx4, i_byte, 5'd0, ST_OK);
                        n_tok_start = 1'b0;
                    end
                end else if (i_byte == CH_SPACE) begin
                    v0          = 1'b1;
                    res0        = mk(EV_TOKEN, TK_MIDDLE, idx4, 8'd0, 5'd0, ST_OK);
                    n_cnt       = cnt_inc;
                    n_tok_start = 1'b1;
                    if (cnt_inc >= CW'(MAX_PARAMS)) begin
                        n_phase = PH_DROP;
                    end
                end else begin
                    v0   = 1'b1;
                    res0 = mk(EV_BYTE, TK_MIDDLE, idx4, i_byte, 5'd0, ST_OK);
                end
            end
            PH_TRAIL: begin
                if (i_byte == CH_END) begin
                    v0   = 1'b1;
                    v1   = 1'b1;
                    res0 = mk(EV_TOKEN, TK_TRAIL, idx4, 8'd0, 5'd0, ST_OK);
                    res1 = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, cnt5_inc, ST_OK);
                end else begin
                    v0   = 1'b1;
                    res0 = mk(EV_BYTE, TK_TRAIL, idx4, i_byte, 5'd0, ST_OK);
                end
            end
            PH_DROP: begin
                if (i_byte == CH_END) begin
                    v0   = 1'b1;
                    res0 = mk(EV_LINE, TK_PREFIX, 4'd0, 8'd0, cnt5, ST_OVERFLOW);
                end
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
        if (i_byte == CH_END) begin
            n_phase     = PH_START;
            n_cnt       = '0;
            n_tok_start = 1'b1;
        end
        res0.last_of_run = !v1;
        res1.last_of_run = 1'b1;
    end

    assign o_pair.v0 = v0;
    assign o_pair.v1 = v1;
    assign o_pair.r0 = res0;
    assign o_pair.r1 = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_cnt       <= '0;
            r_tok_start <= 1'b1;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_tok_start <= n_tok_start;
        end
    end

endmodule

// ===== hdl/irc_line_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top
// streams the bytes of an irc message line out as tagged token results
// ----------------------------------------------------------------------------
// One byte enters per clock, while the result side keeps up, through a one-word input
// register; the parse state steps once per byte and its results land in a two-word
// result register. Most bytes give zero or one result and flow at one byte per clock
// when the result side is ready; a line end that closes a token gives two results,
// and the next byte waits until the second of them has left the result register.
// One word leaves the result register per clock while the result side is ready.
module irc_line_tokenizer_top #(
    parameter int MAX_PARAMS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irc_tok_in_if.sink    i_line,
    irc_tok_out_if.source o_result
);
    import irc_tok_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_v0, r_v1;
    t_result    r_slot0, r_slot1;
    t_res_pair  pair;
    logic       out_fire;
    logic       in_fire;
    logic       free_next;
    logic       s1_go;

    assign out_fire  = r_v0 && o_result.ready;
    // result register can take a new pair once its last word leaves
    assign free_next = !r_v0 || (out_fire && !r_v1);
    assign s1_go     = r_in_valid && free_next;
    assign in_fire   = i_line.valid && i_line.ready;

    assign i_line.ready = !r_in_valid || free_next;

    irc_tok_core #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (s1_go),
        .i_byte (r_in_byte),
        .o_pair (pair)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_line.line_byte;
            end else if (s1_go) begin
                r_in_valid <= 1'b0;
            end
            if (s1_go) begin
                r_v0    <= pair.v0;
                r_v1    <= pair.v1;
                r_slot0 <= pair.r0;
                r_slot1 <= pair.r1;
            end else if (out_fire) begin
                r_v0    <= r_v1;
                r_v1    <= 1'b0;
                r_slot0 <= r_slot1;
            end
        end
    end

    assign o_result.valid       = r_v0;
    assign o_result.event_kind  = r_slot0.event_kind;
    assign o_result.token_kind  = r_slot0.token_kind;
    assign o_result.param_index = r_slot0.param_index;
    assign o_result.data_byte   = r_slot0.data_byte;
    assign o_result.param_count = r_slot0.param_count;
    assign o_result.line_status = r_slot0.line_status;
    assign o_result.last_of_run = r_slot0.last_of_run;

endmodule

// ===== dv/irc_tok_checker.sv =====
// ----------------------------------------------------------------------------
// irc_tok_checker
// watches both channels of the line tokenizer, keeps its own parse state to
// predict the tagged words each accepted byte should produce, and compares
// every result word field by field against the oldest prediction
// ----------------------------------------------------------------------------
module irc_tok_checker #(
    parameter int MAX_PARAMS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    irc_tok_in_if  line_mon,
    irc_tok_out_if result_mon,
    output int     o_mismatches,
    output int     o_outstanding
);
    import irc_tok_pkg::*;

    typedef enum logic [2:0] {
        LS_START,
        LS_PREFIX,
        LS_PRECMD,
        LS_CMD,
        LS_AFTERCMD,
        LS_PARAM,
        LS_TRAIL,
        LS_DROP
    } t_line_phase;

    t_line_phase line_phase;
    logic [4:0]  param_cnt;
    logic        token_fresh;

    t_result     token_words_q[$];
    int          mismatch_count = 0;
    int          pending_words = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_words;

    function automatic void restart_line();
        line_phase  = LS_START;
        param_cnt   = 5'd0;
        token_fresh = 1'b1;
    endfunction

    function automatic t_result make_word(input t_event ev, input t_token tk,
                                          input logic [4:0] idx,
                                          input logic [7:0] db,
                                          input logic [4:0] cnt,
                                          input t_status st);
        t_result w;
        w.event_kind  = ev;
        w.token_kind  = tk;
        w.param_index = idx[3:0];
        w.data_byte   = db;
        w.param_count = cnt;
        w.line_status = st;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    // steps the parse state by one byte and queues the words it gives
    function automatic void tokenize_byte(input logic [7:0] c);
        t_result    run [2];
        int         n;
        logic [4:0] idx;
        n   = 0;
        idx = param_cnt;
        // token kind and index read zero on line-finished words
        case (line_phase)
            LS_START: begin
                if (c == CH_END) begin
                    run[n++] = make_word(EV_LINE, TK_PREFIX, 5'd0, CH_END, 5'd0, ST_EMPTY);
                    restart_line();
                end else if (c == CH_COLON) begin
                    line_phase = LS_PREFIX;
                end else if (c == CH_SPACE) begin
                    line_phase = LS_PRECMD;
                end else begin
                    run[n++] = make_word(EV_BYTE, TK_CMD, 5'd0, c, 5'd0, ST_OK);
                    line_phase = LS_CMD;
                end
            end
            LS_PREFIX: begin
                if (c == CH_END) begin
                    run[n++] = make_word(EV_TOKEN, TK_PREFIX, 5'd0, CH_END, 5'd0, ST_OK);
                    run[n++] = make_word(EV_LINE, TK_PREFIX, 5'd0, CH_END, 5'd0, ST_EMPTY);
                    restart_line();
                end else if (c == CH_SPACE) begin
                    run[n++] = make_word(EV_TOKEN, TK_PREFIX, 5'd0, CH_END, 5'd0, ST_OK);
                    line_phase = LS_PRECMD;
                end else begin
                    run[n++] = make_word(EV_BYTE, TK_PREFIX, 5'd0, c, 5'd0, ST_OK);
                end
            end
            LS_PRECMD: begin
                if (c == CH_END) begin
                    run[n++] = make_word(EV_LINE, TK_PREFIX, 5'd0, CH_END, 5'd0, ST_NO_CMD);
                    restart_line();
                end else if (c != CH_SPACE) begin
                    run[n++] = make_word(EV_BYTE, TK_CMD, 5'd0, c, 5'd0, ST_OK);
                    line_phase = LS_CMD;
                end
            end
            LS_CMD: begin
                if (c == CH_END) begin
                    run[n++] = make_word(EV_TOKEN, TK_CMD, 5'd0, CH_END, 5'd0, ST_OK);
                    run[n++] = make_word(EV_LINE, TK_PREFIX, 5'd0, CH_END, 5'd0, ST_OK);
                    restart_line();
                end else if (c == CH_SPACE) begin
                    run[n++] = make_word(EV_TOKEN, TK_CMD, 5'd0, CH_END, 5'd0, ST_OK);
                    line_phase = LS_AFTERCMD;
                end else begin
                    run[n++] = make_word(EV_BYTE, TK_CMD, 5'd0, c, 5'd0, ST_OK);
                end
            end
            LS_AFTERCMD: begin
                if (c == CH_END) begin
                    run[n++] = make_word(EV_LINE, TK_PREFIX, 5'd0, CH_END, 5'd0, ST_OK);
                    restart_line();
                end else if (c == CH_COLON) begin
                    line_phase = LS_TRAIL;
                end else if (c != CH_SPACE) begin
                    run[n++] = make_word(EV_BYTE, TK_MIDDLE, idx, c, 5'd0, ST_OK);
                    line_phase  = LS_PARAM;
                    token_fresh = 1'b0;
                end
            end
            LS_PARAM: begin
                if (c == CH_END) begin
                    // a space right before the end leaves an empty param, still counted
                    run[n++] = make_word(EV_TOKEN, TK_MIDDLE, idx, CH_END, 5'd0, ST_OK);
                    run[n++] = make_word(EV_LINE, TK_PREFIX, 5'd0, CH_END, idx + 5'd1,
                                         ST_OK);
                    restart_line();
                end else if (token_fresh) begin
                    if (c == CH_COLON) begin
                        line_phase = LS_TRAIL;
                    end else if (c != CH_SPACE) begin
                        run[n++] = make_word(EV_BYTE, TK_MIDDLE, idx, c, 5'd0, ST_OK);
                        token_fresh = 1'b0;
                    end
                end else if (c == CH_SPACE) begin
                    run[n++] = make_word(EV_TOKEN, TK_MIDDLE, idx, CH_END, 5'd0, ST_OK);
                    param_cnt   = param_cnt + 5'd1;
                    token_fresh = 1'b1;
                    if (param_cnt >= MAX_PARAMS) begin
                        line_phase = LS_DROP;
                    end
                end else begin
                    run[n++] = make_word(EV_BYTE, TK_MIDDLE, idx, c, 5'd0, ST_OK);
                end
            end
            LS_TRAIL: begin
                if (c == CH_END) begin
                    run[n++] = make_word(EV_TOKEN, TK_TRAIL, idx, CH_END, 5'd0, ST_OK);
                    run[n++] = make_word(EV_LINE, TK_PREFIX, 5'd0, CH_END, idx + 5'd1,
                                         ST_OK);
                    restart_line();
                end else begin
                    run[n++] = make_word(EV_BYTE, TK_TRAIL, idx, c, 5'd0, ST_OK);
                end
            end
            default: begin
                // too many params: everything up to line end is dropped
                if (c == CH_END) begin
                    run[n++] = make_word(EV_LINE, TK_PREFIX, 5'd0, CH_END, idx, ST_OVERFLOW);
                    restart_line();
                end
            end
        endcase
        if (n > 0) begin
            run[n - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            token_words_q.push_back(run[i]);
        end
    endfunction

    function automatic bit field_ok(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: result %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        bit      ok;
        if (!i_rst_n) begin
            restart_line();
            token_words_q.delete();
        end else begin
            if (line_mon.valid && line_mon.ready) begin
                tokenize_byte(line_mon.line_byte);
            end
            if (result_mon.valid && result_mon.ready) begin
                if (token_words_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual ev %0d tk %0d",
                             $time, result_mon.event_kind, result_mon.token_kind);
                    mismatch_count++;
                end else begin
                    want = token_words_q.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("event_kind", want.event_kind, result_mon.event_kind);
                    ok &= field_ok("token_kind", want.token_kind, result_mon.token_kind);
                    ok &= field_ok("param_index", want.param_index, result_mon.param_index);
                    ok &= field_ok("data_byte", want.data_byte, result_mon.data_byte);
                    ok &= field_ok("param_count", want.param_count, result_mon.param_count);
                    ok &= field_ok("line_status", want.line_status, result_mon.line_status);
                    ok &= field_ok("last_of_run", want.last_of_run, result_mon.last_of_run);
                    if (!ok) begin
                        mismatch_count++;
                    end
                end
            end
        end
        pending_words <= token_words_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives irc lines into the tokenizer byte by byte: a short directed set of
// corner lines, then mostly well-formed random lines with noise mixed in, with
// random idle bursts on both channels, a long result back-pressure and a full
// drain pause; the checker beside the block predicts and compares the words
// ----------------------------------------------------------------------------
module testbench;
    import irc_tok_pkg::*;

    localparam int MAX_PARAMS = 16;
    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 11;
    localparam int LONG_HOLD = 64;
    localparam int TAIL_CYCLES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int   mismatches;
    int   outstanding;
    int   bytes_sent = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_requests = 0;
    int   holds_served = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    irc_tok_in_if  line_if ();
    irc_tok_out_if result_if ();

    irc_line_tokenizer_top #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_line   (line_if),
        .o_result (result_if)
    );

    irc_tok_checker #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .line_mon      (line_if),
        .result_mon    (result_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // offers one byte and returns at the falling edge after it is taken
    task automatic send_byte(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            line_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        line_if.valid     <= 1'b1;
        line_if.line_byte <= b;
        do @(posedge i_clk); while (!line_if.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        line_if.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [7:0] name_byte(input bit allow_colon);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == CH_SPACE || (!allow_colon && b == CH_COLON));
        return b;
    endfunction

    task automatic send_random_line();
        logic [7:0] line_q[$];
        int         nparams;
        int         plen;
        if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 2) == 0) begin
                line_q.push_back(CH_COLON);
                repeat ($urandom_range(0, 5)) line_q.push_back(name_byte(1'b1));
                repeat ($urandom_range(1, 3)) line_q.push_back(CH_SPACE);
            end
            line_q.push_back(name_byte(1'b0));
            repeat ($urandom_range(0, 5)) line_q.push_back(name_byte(1'b1));
            // now and then enough params to come near, reach or pass the limit
            if ($urandom_range(0, 7) == 0) begin
                nparams = $urandom_range(MAX_PARAMS - 2, MAX_PARAMS + 2);
                plen = 1;
            end else begin
                nparams = $urandom_range(0, 4);
                plen = 4;
            end
            repeat (nparams) begin
                repeat ($urandom_range(1, 3)) line_q.push_back(CH_SPACE);
                line_q.push_back(name_byte(1'b0));
                repeat ($urandom_range(0, plen - 1)) line_q.push_back(name_byte(1'b1));
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
                line_q.push_back(CH_COLON);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 3))
                        0: line_q.push_back(CH_SPACE);
                        1: line_q.push_back(CH_COLON);
                        default: line_q.push_back(name_byte(1'b1));
                    endcase
                end
            end else if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) line_q.push_back(CH_SPACE);
            end
        end else begin
            // noise: separators, stray line ends and arbitrary bytes
            repeat ($urandom_range(0, 10)) begin
                case ($urandom_range(0, 11))
                    0, 1, 2, 3: line_q.push_back(CH_SPACE);
                    4, 5:       line_q.push_back(CH_COLON);
                    6:          line_q.push_back(CH_END);
                    default:    line_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        line_q.push_back(CH_END);
        foreach (line_q[i]) begin
            send_byte(line_q[i]);
        end
    endtask

    task automatic send_lines(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            send_random_line();
        end
    endtask

    initial begin : result_drain
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] corner_q[$];
        corner_q = '{
            CH_END,
            CH_COLON, 8'hFF, CH_END,
            CH_COLON, 8'h01, CH_SPACE, CH_END,
            CH_SPACE, CH_END,
            "A", CH_SPACE, CH_END,
            "B", CH_SPACE, "p", CH_COLON, CH_SPACE, CH_END,
            "C", CH_SPACE, CH_COLON, "x", CH_SPACE, CH_END
        };
        line_if.valid     = 1'b0;
        line_if.line_byte = 8'h00;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 10;
        foreach (corner_q[i]) begin
            send_byte(corner_q[i]);
        end

        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_lines(140);

        // result side stalls long while bytes keep coming
        hold_requests++;
        send_lines(40);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_lines(80);

        send_idle_pct = 40;
        recv_idle_pct = 40;
        send_lines(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_lines(60);

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * 400000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
